// ===== hw/rtl/otpa_pkg.sv =====
package otpa_pkg;

    // Width of the whole-unit odometer and of the trip distance.
    localparam int UNIT_BITS = 20;
    localparam int FRAC_BITS = 16;
    localparam int CALIB_BITS = 17;

    localparam logic [FRAC_BITS-1:0]  RATE_RESET = 16'd7692;
    localparam logic [CALIB_BITS-1:0] CALIB_MAX = 17'd99999;
    localparam logic signed [4:0]     ROLLER_SPAN = 5'sd10;
    localparam logic signed [4:0]     ROLLER_HALF = 5'sd5;

    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_TRIP_RESET  = 2'd1;
    localparam logic [1:0] CMD_CALIB_RESET = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] pulse_count;
        logic       engine_on;
        logic       calib_active;
        logic [3:0] roller_position;
    } t_in_word;

    typedef struct packed {
        logic [UNIT_BITS-1:0]  odo_units;
        logic [FRAC_BITS-1:0]  odo_fraction;
        logic [UNIT_BITS-1:0]  trip_units;
        logic [CALIB_BITS-1:0] calib_count;
        logic                  save_request;
    } t_out_word;

    typedef struct packed {
        logic [FRAC_BITS-1:0]  fraction_acc;
        logic [UNIT_BITS-1:0]  unit_count;
        logic [UNIT_BITS-1:0]  trip_base_units;
        logic [FRAC_BITS-1:0]  trip_base_fraction;
        logic                  engine_was_on;
        logic [CALIB_BITS-1:0] calib_acc;
        logic [3:0]            roller_prev;
    } t_state;

endpackage

// ===== hw/rtl/otpa_step.sv =====
module otpa_step
    import otpa_pkg::*;
(
    input  t_state               i_state,
    input  t_in_word             i_word,
    input  logic [FRAC_BITS-1:0] i_pulses_per_unit,
    output t_state               o_state,
    output t_out_word            o_word
);

    logic [FRAC_BITS:0]      frac_sum;
    logic [FRAC_BITS:0]      frac_sub;
    logic                    unit_inc;
    logic [FRAC_BITS-1:0]    frac_next;
    logic signed [4:0]       roller_diff;
    logic signed [4:0]       roller_adj;
    logic signed [18:0]      calib_sum;
    logic [CALIB_BITS-1:0]   calib_next;
    logic                    engine_fell;
    logic signed [UNIT_BITS:0] trip_diff;
    logic                    trip_borrow;
    t_state                  nxt;
    logic                    save;

    // Fraction accumulator: one subtraction of the rate at most per tick.
    always_comb begin
        frac_sum  = {1'b0, i_state.fraction_acc} + (FRAC_BITS+1)'(i_word.pulse_count);
        unit_inc  = (frac_sum >= {1'b0, i_pulses_per_unit});
        frac_sub  = unit_inc ? (frac_sum - {1'b0, i_pulses_per_unit}) : frac_sum;
        frac_next = frac_sub[FRAC_BITS] ? {FRAC_BITS{1'b1}} : frac_sub[FRAC_BITS-1:0];
    end

    // Roller delta folded into the shortest way around the ten digits.
    always_comb begin
        roller_diff = $signed({1'b0, i_word.roller_position}) -
                      $signed({1'b0, i_state.roller_prev});
        if (roller_diff > ROLLER_HALF) begin
            roller_adj = roller_diff - ROLLER_SPAN;
        end else if (roller_diff < -ROLLER_HALF) begin
            roller_adj = roller_diff + ROLLER_SPAN;
        end else begin
            roller_adj = roller_diff;
        end
        calib_sum = $signed({2'b00, i_state.calib_acc}) +
                    $signed({11'd0, i_word.pulse_count}) +
                    $signed({{14{roller_adj[4]}}, roller_adj});
        if (calib_sum < 0) begin
            calib_next = '0;
        end else if (calib_sum > $signed({2'b00, CALIB_MAX})) begin
            calib_next = CALIB_MAX;
        end else begin
            calib_next = calib_sum[CALIB_BITS-1:0];
        end
    end

    assign engine_fell = i_state.engine_was_on && !i_word.engine_on;

    always_comb begin
        nxt  = i_state;
        save = 1'b0;
        case (i_word.command)
            CMD_TICK: begin
                nxt.fraction_acc  = frac_next;
                nxt.unit_count    = i_state.unit_count + UNIT_BITS'(unit_inc);
                nxt.engine_was_on = i_word.engine_on;
                save              = unit_inc || engine_fell;
                if (i_word.calib_active) begin
                    nxt.calib_acc   = calib_next;
                    nxt.roller_prev = i_word.roller_position;
                end else begin
                    nxt.calib_acc = '0;
                end
            end
            CMD_TRIP_RESET: begin
                nxt.trip_base_units    = i_state.unit_count;
                nxt.trip_base_fraction = i_state.fraction_acc;
                save                   = 1'b1;
            end
            CMD_CALIB_RESET: begin
                nxt.calib_acc = '0;
            end
            default: begin
                nxt = i_state;
            end
        endcase
    end

    // Trip distance from the updated state, clamped at zero.
    always_comb begin
        trip_borrow = (nxt.fraction_acc < nxt.trip_base_fraction);
        trip_diff   = $signed({1'b0, nxt.unit_count}) -
                      $signed({1'b0, nxt.trip_base_units}) -
                      $signed((UNIT_BITS+1)'(trip_borrow));
    end

    assign o_state             = nxt;
    assign o_word.odo_units    = nxt.unit_count;
    assign o_word.odo_fraction = nxt.fraction_acc;
    assign o_word.trip_units   = trip_diff[UNIT_BITS] ? '0 : trip_diff[UNIT_BITS-1:0];
    assign o_word.calib_count  = nxt.calib_acc;
    assign o_word.save_request = save;

endmodule

// ===== hw/rtl/odometer_trip_pulse_accumulator.sv =====
// An accepted word goes through the input register, then the state and result registers.
// One word per cycle unless the output stalls; the state update is one pass of adds and compares.
// A result waiting on a stalled output still leaves room for one more word in the input register.
// Reset (synchronous, active low) clears all counters, sets the engine-was-on flag,
// restores pulses_per_unit to 7692 and empties both registers.
module odometer_trip_pulse_accumulator
    import otpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [FRAC_BITS-1:0] i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word
);

    logic [FRAC_BITS-1:0] r_ppu;
    logic                 r_in_valid;
    t_in_word             r_in_word;
    logic                 r_out_valid;
    t_out_word            r_out_word;
    t_state               r_state;
    t_state               n_state;
    t_out_word            n_out_word;
    logic                 advance;
    logic                 in_accept;

    // The input register moves into the state and result registers whenever the
    // result register is empty or its word is being taken in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    // The input side stalls only when both registers hold a word that cannot move.
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    otpa_step u_step (
        .i_state          (r_state),
        .i_word           (r_in_word),
        .i_pulses_per_unit(r_ppu),
        .o_state          (n_state),
        .o_word           (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppu <= RATE_RESET;
        end else if (i_cfg_wr_en) begin
            r_ppu <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    // Architectural state updates exactly once per word, when it moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.fraction_acc       <= '0;
            r_state.unit_count         <= '0;
            r_state.trip_base_units    <= '0;
            r_state.trip_base_fraction <= '0;
            r_state.engine_was_on      <= 1'b1;
            r_state.calib_acc          <= '0;
            r_state.roller_prev        <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The calibration count never leaves its saturation range.
    a_calib_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.calib_acc <= CALIB_MAX)
        else $error("calibration count above its maximum");

    // A word held in the input register is not dropped while the output is blocked.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_word)))
        else $error("input word lost while output stalled");

    // Every word that moves on shows up as a result in the next cycle.
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register did not load");

    // Reset leaves the engine-was-on flag set so a first tick with the engine off saves.
    a_reset_engine: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state.engine_was_on && !r_in_valid && !r_out_valid))
        else $error("reset state wrong");

endmodule
